// ----- design/rwg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwg_pkg
// Shared types and constants of the fractional-N PLL register word generator.
// ----------------------------------------------------------------------------
package rwg_pkg;

  localparam int FRAC_MODULUS_DEF = 4095;

  localparam int WORD_W = 32;
  localparam int PFD_W  = 28;
  localparam int VCO_W  = 33;
  localparam int RDIV_W = 10;
  localparam int INT_W  = 16;
  localparam int FRAC_W = 12;
  localparam int SEL_W  = 3;
  localparam int NUM_WORDS = 6;
  localparam int MAX_DOUBLINGS = 6;

  localparam logic [WORD_W-1:0] LO_MIN  = 32'd35000000;
  localparam logic [VCO_W-1:0]  VCO_MIN = 33'd2200000000;
  localparam logic [VCO_W-1:0]  VCO_MAX = 33'd4400000000;
  localparam logic [VCO_W-1:0]  INT_MIN = 33'd23;
  localparam logic [VCO_W-1:0]  INT_MAX = 33'd65535;

  localparam logic [WORD_W-1:0] W_R5 = 32'h0058_0005;
  localparam logic [WORD_W-1:0] W_R4 = 32'h008C_703C;
  localparam logic [WORD_W-1:0] W_R3 = 32'h00C8_04B3;
  localparam logic [WORD_W-1:0] W_R2 = 32'h0E00_8E42;
  localparam logic [WORD_W-1:0] R4_SEL_CLEAR = 32'hFF8F_FFFF;
  localparam int SEL_LSB = 20;

  typedef enum logic [1:0] {
    CFG_IF_HZ  = 2'd0,
    CFG_REF_HZ = 2'd1,
    CFG_R_DIV  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RF_LE_IF = 3'd1,
    ST_LO_RANGE = 3'd2,
    ST_VCO_OVER = 3'd3,
    ST_PFD_ZERO = 3'd4,
    ST_INT_FRAC = 3'd5
  } status_t;

  typedef struct packed {
    logic    start;
    status_t status;
  } emit_req_t;

  typedef struct packed {
    logic [INT_W-1:0]  int_value;
    logic [FRAC_W-1:0] frac_value;
    logic [SEL_W-1:0]  divider_select;
    logic [WORD_W-1:0] lo_value;
  } pll_vals_t;

endpackage

// ----- design/rwg_serial_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwg_serial_div
// Radix-2 restoring divider, one quotient bit per cycle. The dividend is
// loaded left-aligned and the quotient shifts in at the bottom.
// ----------------------------------------------------------------------------
module rwg_serial_div #(
  parameter int REM_W = rwg_pkg::PFD_W,
  parameter int DVD_W = rwg_pkg::VCO_W,
  parameter int CNT_W = $clog2(rwg_pkg::VCO_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] steps,
  input  logic [REM_W-1:0] dsor,
  input  logic [REM_W-1:0] rem_init,
  input  logic [DVD_W-1:0] dvd_init,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [REM_W-1:0] rem
);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] dsor_q;
  logic [DVD_W-1:0] dvd;
  logic [REM_W:0]   rem_sh;
  logic [REM_W:0]   diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dsor_q};
    diff   = rem_sh - {1'b0, dsor_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= steps;
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsor_q <= dsor;
      rem    <= rem_init;
      dvd    <= dvd_init;
    end else if (running) begin
      rem <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

  assign quot = dvd;

endmodule

// ----- design/rwg_serial_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwg_serial_mul
// Shift-add multiplier by the constant modulus, one multiplier bit per cycle,
// with an addend preloaded into the accumulator.
// ----------------------------------------------------------------------------
module rwg_serial_mul #(
  parameter int FRAC_MODULUS = rwg_pkg::FRAC_MODULUS_DEF,
  parameter int MOD_W        = $clog2(FRAC_MODULUS + 1),
  parameter int IN_W         = rwg_pkg::PFD_W,
  parameter int PROD_W       = IN_W + MOD_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   mcand,
  input  logic [IN_W-1:0]   addend,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int IDX_W = $clog2(MOD_W);
  localparam logic [MOD_W-1:0] MULT = MOD_W'(FRAC_MODULUS);

  logic              running;
  logic [IDX_W-1:0]  idx;
  logic [PROD_W-1:0] mc;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      idx     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        idx     <= '0;
      end else if (running) begin
        idx <= idx + IDX_W'(1);
        if (idx == IDX_W'(MOD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(addend);
      mc   <= PROD_W'(mcand);
    end else if (running) begin
      if (MULT[idx]) begin
        prod <= prod + mc;
      end
      mc <= {mc[PROD_W-2:0], 1'b0};
    end
  end

endmodule

// ----- design/rwg_word_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwg_word_out
// Emits the register words R5 down to R0 one per cycle, or a single status
// word when the run failed.
// ----------------------------------------------------------------------------
module rwg_word_out #(
  parameter int FRAC_MODULUS = rwg_pkg::FRAC_MODULUS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rwg_pkg::emit_req_t         req,
  input  rwg_pkg::pll_vals_t         vals,
  output logic                       finishing,
  output logic                       word_valid,
  output logic [rwg_pkg::WORD_W-1:0] reg_word,
  output logic                       last_word,
  output logic [2:0]                 status,
  output logic [rwg_pkg::WORD_W-1:0] lo_hz
);

  logic                  active;
  logic [2:0]            word_index;
  rwg_pkg::status_t      run_status;
  logic                  is_err;
  logic                  is_last;
  logic [rwg_pkg::WORD_W-1:0] word_sel;
  logic [rwg_pkg::WORD_W-1:0] r4;
  logic [rwg_pkg::WORD_W-1:0] r1;
  logic [rwg_pkg::WORD_W-1:0] r0;

  always_comb begin
    is_err    = run_status != rwg_pkg::ST_OK;
    is_last   = is_err || (word_index == 3'(rwg_pkg::NUM_WORDS - 1));
    finishing = active && is_last;
    r4 = (rwg_pkg::W_R4 & rwg_pkg::R4_SEL_CLEAR)
         | (rwg_pkg::WORD_W'(vals.divider_select) << rwg_pkg::SEL_LSB);
    r1 = {16'h0000, 1'b1, rwg_pkg::FRAC_W'(FRAC_MODULUS), 3'b001};
    r0 = {1'b0, vals.int_value, vals.frac_value, 3'b000};
    case (word_index)
      3'd0:    word_sel = rwg_pkg::W_R5;
      3'd1:    word_sel = r4;
      3'd2:    word_sel = rwg_pkg::W_R3;
      3'd3:    word_sel = rwg_pkg::W_R2;
      3'd4:    word_sel = r1;
      3'd5:    word_sel = r0;
      default: word_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      word_index <= '0;
      run_status <= rwg_pkg::ST_OK;
      word_valid <= 1'b0;
    end else begin
      word_valid <= active;
      if (req.start) begin
        active     <= 1'b1;
        word_index <= '0;
        run_status <= req.status;
      end else if (active) begin
        word_index <= word_index + 3'd1;
        if (is_last) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      reg_word  <= is_err ? '0 : word_sel;
      last_word <= is_last;
      status    <= run_status;
      lo_hz     <= (is_last && !is_err) ? vals.lo_value : '0;
    end
  end

endmodule

// ----- design/pll_frac_n_register_word_gen_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_frac_n_register_word_gen_unit
// Turns a requested RF frequency into the six register words of a
// fractional-N PLL, or into one status word when the request cannot be met.
// ----------------------------------------------------------------------------
// A frequency on rf_hz is taken at a clock edge where start is high and busy
// is low. The block subtracts if_hz, range-checks the LO, doubles it into the
// VCO band, and divides by the PFD frequency with one shared bit-serial
// divider: first ref_hz / r_div (skipped when r_div is zero), then the VCO
// frequency by the PFD, then the scaled remainder for the rounded FRAC.
// The remainder scaling is a bit-serial multiply by the modulus.
// Results leave as words on reg_word, last_word, status and lo_hz, one per
// cycle while word_valid is high; a good run gives six words, R5 first,
// and a failed run gives a single word with reg_word zero.
// The divider's one bit per cycle sets the run time, which is longer with r_div
// nonzero since ref_hz / r_div is divided first. Errors found early finish sooner.
// The next start is taken in the cycle the last word is shown.
// Configuration is written through cfg_wr, cfg_idx and cfg_data by the user only while idle; not enforced here.
// Reset restores if_hz 0, ref_hz 25 MHz and r_div 1, and returns to idle.
// Words cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module pll_frac_n_register_word_gen_unit #(
  parameter int FRAC_MODULUS = rwg_pkg::FRAC_MODULUS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] rf_hz,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output logic        word_valid,
  output logic [31:0] reg_word,
  output logic        last_word,
  output logic [2:0]  status,
  output logic [31:0] lo_hz
);

  localparam int MOD_W  = $clog2(FRAC_MODULUS + 1);
  localparam int PFD_W  = rwg_pkg::PFD_W;
  localparam int VCO_W  = rwg_pkg::VCO_W;
  localparam int PROD_W = PFD_W + MOD_W;
  localparam int CNT_W  = $clog2(VCO_W + 1);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_RANGE     = 14'b00000000000010,
    S_DOUBLE    = 14'b00000000000100,
    S_PFD_GO    = 14'b00000000001000,
    S_PFD_WAIT  = 14'b00000000010000,
    S_VCO_GO    = 14'b00000000100000,
    S_VCO_WAIT  = 14'b00000001000000,
    S_MUL_GO    = 14'b00000010000000,
    S_MUL_WAIT  = 14'b00000100000000,
    S_FRAC_GO   = 14'b00001000000000,
    S_FRAC_WAIT = 14'b00010000000000,
    S_CHECK     = 14'b00100000000000,
    S_EMIT_GO   = 14'b01000000000000,
    S_EMIT      = 14'b10000000000000
  } state_t;

  state_t state;

  logic [31:0]                if_hz;
  logic [PFD_W-1:0]           ref_hz;
  logic [rwg_pkg::RDIV_W-1:0] r_div;

  logic [31:0]             lo;
  logic                    rf_le;
  logic [VCO_W-1:0]        vco;
  logic [rwg_pkg::SEL_W-1:0] sel;
  logic [PFD_W-1:0]        pfd;
  logic [VCO_W-1:0]        ival;
  logic [PFD_W-1:0]        vrem;
  logic [rwg_pkg::FRAC_W-1:0] fval;
  rwg_pkg::status_t        fail_status;
  rwg_pkg::pll_vals_t      vals;

  logic                    div_start;
  logic [CNT_W-1:0]        div_steps;
  logic [PFD_W-1:0]        div_dsor;
  logic [PFD_W-1:0]        div_rem_init;
  logic [VCO_W-1:0]        div_dvd;
  logic                    div_done;
  logic [VCO_W-1:0]        div_quot;
  logic [PFD_W-1:0]        div_rem;

  logic                    mul_start;
  logic                    mul_done;
  logic [PROD_W-1:0]       mul_prod;

  rwg_pkg::emit_req_t      emit_req;
  logic                    emit_finishing;
  logic [MOD_W-1:0]        fq;

  assign busy = state != S_IDLE;
  assign fq   = div_quot[MOD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      if_hz  <= '0;
      ref_hz <= PFD_W'(25000000);
      r_div  <= rwg_pkg::RDIV_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        rwg_pkg::CFG_IF_HZ:  if_hz  <= cfg_data;
        rwg_pkg::CFG_REF_HZ: ref_hz <= cfg_data[PFD_W-1:0];
        rwg_pkg::CFG_R_DIV:  r_div  <= cfg_data[rwg_pkg::RDIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_steps    = CNT_W'(VCO_W);
    div_dsor     = pfd;
    div_rem_init = '0;
    div_dvd      = vco;
    mul_start    = state == S_MUL_GO;
    emit_req.start  = state == S_EMIT_GO;
    emit_req.status = fail_status;
    case (state)
      S_PFD_GO: begin
        div_start = 1'b1;
        div_steps = CNT_W'(PFD_W);
        div_dsor  = PFD_W'(r_div);
        div_dvd   = {ref_hz, {(VCO_W - PFD_W){1'b0}}};
      end
      S_VCO_GO: begin
        div_start = 1'b1;
      end
      S_FRAC_GO: begin
        div_start    = 1'b1;
        div_steps    = CNT_W'(MOD_W);
        div_rem_init = mul_prod[PROD_W-1:MOD_W];
        div_dvd      = {mul_prod[MOD_W-1:0], {(VCO_W - MOD_W){1'b0}}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fail_status <= rwg_pkg::ST_OK;
      vals        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            fail_status <= rwg_pkg::ST_OK;
            state       <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (rf_le) begin
            fail_status <= rwg_pkg::ST_RF_LE_IF;
            state       <= S_EMIT_GO;
          end else if (lo < rwg_pkg::LO_MIN || {1'b0, lo} > rwg_pkg::VCO_MAX) begin
            fail_status <= rwg_pkg::ST_LO_RANGE;
            state       <= S_EMIT_GO;
          end else begin
            state <= S_DOUBLE;
          end
        end
        S_DOUBLE: begin
          if (!(vco < rwg_pkg::VCO_MIN && sel < rwg_pkg::SEL_W'(rwg_pkg::MAX_DOUBLINGS))) begin
            if (vco > rwg_pkg::VCO_MAX) begin
              fail_status <= rwg_pkg::ST_VCO_OVER;
              state       <= S_EMIT_GO;
            end else if (r_div == '0) begin
              state <= S_VCO_GO;
            end else begin
              state <= S_PFD_GO;
            end
          end
        end
        S_PFD_GO:  state <= S_PFD_WAIT;
        S_PFD_WAIT: begin
          if (div_done) begin
            if (div_quot[PFD_W-1:0] == '0) begin
              fail_status <= rwg_pkg::ST_PFD_ZERO;
              state       <= S_EMIT_GO;
            end else begin
              state <= S_VCO_GO;
            end
          end
        end
        S_VCO_GO:  state <= S_VCO_WAIT;
        S_VCO_WAIT: begin
          if (div_done) begin
            state <= S_MUL_GO;
          end
        end
        S_MUL_GO:  state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            state <= S_FRAC_GO;
          end
        end
        S_FRAC_GO: state <= S_FRAC_WAIT;
        S_FRAC_WAIT: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ival < rwg_pkg::INT_MIN || ival > rwg_pkg::INT_MAX) begin
            fail_status <= rwg_pkg::ST_INT_FRAC;
          end else begin
            vals.int_value      <= ival[rwg_pkg::INT_W-1:0];
            vals.frac_value     <= fval;
            vals.divider_select <= sel;
            vals.lo_value       <= lo;
          end
          state <= S_EMIT_GO;
        end
        S_EMIT_GO: state <= S_EMIT;
        S_EMIT: begin
          if (emit_finishing) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lo    <= rf_hz - if_hz;
        rf_le <= rf_hz <= if_hz;
        sel   <= '0;
        pfd   <= PFD_W'(1);
      end
      S_RANGE: vco <= VCO_W'(lo);
      S_DOUBLE: begin
        if (vco < rwg_pkg::VCO_MIN && sel < rwg_pkg::SEL_W'(rwg_pkg::MAX_DOUBLINGS)) begin
          vco <= {vco[VCO_W-2:0], 1'b0};
          sel <= sel + rwg_pkg::SEL_W'(1);
        end
      end
      S_PFD_WAIT: begin
        if (div_done) begin
          pfd <= div_quot[PFD_W-1:0];
        end
      end
      S_VCO_WAIT: begin
        if (div_done) begin
          ival <= div_quot;
          vrem <= div_rem;
        end
      end
      S_FRAC_WAIT: begin
        if (div_done) begin
          if (fq >= MOD_W'(FRAC_MODULUS)) begin
            fval <= '0;
            ival <= ival + VCO_W'(1);
          end else begin
            fval <= rwg_pkg::FRAC_W'(fq);
          end
        end
      end
      default: ;
    endcase
  end

  rwg_serial_div #(
    .REM_W (PFD_W),
    .DVD_W (VCO_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .dsor     (div_dsor),
    .rem_init (div_rem_init),
    .dvd_init (div_dvd),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  rwg_serial_mul #(
    .FRAC_MODULUS (FRAC_MODULUS),
    .MOD_W        (MOD_W),
    .IN_W         (PFD_W),
    .PROD_W       (PROD_W)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (vrem),
    .addend ({1'b0, pfd[PFD_W-1:1]}),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  rwg_word_out #(
    .FRAC_MODULUS (FRAC_MODULUS)
  ) u_word_out (
    .clk        (clk),
    .rst        (rst),
    .req        (emit_req),
    .vals       (vals),
    .finishing  (emit_finishing),
    .word_valid (word_valid),
    .reg_word   (reg_word),
    .last_word  (last_word),
    .status     (status),
    .lo_hz      (lo_hz)
  );

  // A started request keeps the block busy on the following cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted request");

  // Words before the last one come only while a run is in progress.
  a_word_in_run: assert property (@(posedge clk) disable iff (rst)
    word_valid && !last_word |-> busy)
    else $error("non-final word outside a run");

  // The words of a good run follow each other without gaps.
  a_words_contiguous: assert property (@(posedge clk) disable iff (rst)
    word_valid && !last_word |=> word_valid)
    else $error("gap between words of a run");

  // A failed run gives exactly one word, zero, marked last.
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    word_valid && status != rwg_pkg::ST_OK |-> last_word && reg_word == '0)
    else $error("error word malformed");

endmodule
